FILE: design/bbe_pkg.sv
// Shared types, constants and the reciprocal table of the 3x3 edge-aware box blur.
// No dependencies; every other file in this folder imports it.
package bbe_pkg;

  localparam int unsigned DIM_W          = 11;
  localparam int unsigned CH_W           = 8;
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 11'd480;

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Item kinds carried on tuser
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // Datapath widths: column sum of 3 bytes, window sum of 9 bytes, 2*sum+n
  localparam int unsigned COL_SUM_W = 10;
  localparam int unsigned WIN_SUM_W = 12;
  localparam int unsigned NUM_W     = 13;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned REC_W     = 18;
  localparam int unsigned REC_SHIFT = 18;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

  // One window column: top is the oldest row, bot the newest
  typedef struct packed {
    rgb_t bot;
    rgb_t mid;
    rgb_t top;
  } column_t;

  typedef struct packed {
    logic [COL_SUM_W-1:0] blue;
    logic [COL_SUM_W-1:0] green;
    logic [COL_SUM_W-1:0] red;
  } col_sum_t;

  typedef struct packed {
    logic col_en;
    logic top_en;
    logic bot_en;
  } cell_mask_t;

  // In-frame neighbours of the output pixel
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } win_mask_t;

  // ceil(2^REC_SHIFT / (2*n)); exact for every numerator below 2^NUM_W
  function automatic logic [REC_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [REC_W-1:0] m;
    case (cnt)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd6:    m = 18'd21846;
      4'd9:    m = 18'd14564;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

FILE: design/bbe_line_store.sv
// Two line stores (upper and lower row) sharing one column address, read data registered.
// Depends on bbe_pkg for the pixel type.
module bbe_line_store import bbe_pkg::*; #(
  parameter int unsigned DEPTH = DEF_MAX_WIDTH,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] addr_i,
  input  rgb_t          wr_upper_i,
  input  rgb_t          wr_lower_i,
  output rgb_t          rd_upper_o,
  output rgb_t          rd_lower_o
);

  rgb_t upper_mem [DEPTH];
  rgb_t lower_mem [DEPTH];
  rgb_t rd_upper_q;
  rgb_t rd_lower_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[addr_i] <= wr_upper_i;
    end
    if (rd_en_i) begin
      rd_upper_q <= upper_mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      lower_mem[addr_i] <= wr_lower_i;
    end
    if (rd_en_i) begin
      rd_lower_q <= lower_mem[addr_i];
    end
  end

  assign rd_upper_o = rd_upper_q;
  assign rd_lower_o = rd_lower_q;

endmodule

FILE: design/bbe_cell.sv
// One window cell: holds a three-pixel column, hands it on at each shift and
// gives the masked per-channel sum of its column. Depends on bbe_pkg.
module bbe_cell import bbe_pkg::*; (
  input  logic       clk_i,
  input  logic       shift_i,
  input  column_t    col_i,
  input  cell_mask_t mask_i,
  output column_t    col_o,
  output col_sum_t   sum_o
);

  column_t col_q;
  logic    en_top;
  logic    en_mid;
  logic    en_bot;

  function automatic logic [COL_SUM_W-1:0] chan_sum(input logic [CH_W-1:0] a,
                                                    input logic [CH_W-1:0] b,
                                                    input logic [CH_W-1:0] c,
                                                    input logic ea,
                                                    input logic eb,
                                                    input logic ec);
    logic [COL_SUM_W-1:0] s;
    s = (ea ? COL_SUM_W'(a) : '0) + (eb ? COL_SUM_W'(b) : '0) + (ec ? COL_SUM_W'(c) : '0);
    return s;
  endfunction

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign en_top = mask_i.col_en & mask_i.top_en;
  assign en_mid = mask_i.col_en;
  assign en_bot = mask_i.col_en & mask_i.bot_en;

  always_comb begin
    sum_o.red   = chan_sum(col_q.top.red, col_q.mid.red, col_q.bot.red,
                           en_top, en_mid, en_bot);
    sum_o.green = chan_sum(col_q.top.green, col_q.mid.green, col_q.bot.green,
                           en_top, en_mid, en_bot);
    sum_o.blue  = chan_sum(col_q.top.blue, col_q.mid.blue, col_q.bot.blue,
                           en_top, en_mid, en_bot);
  end

  assign col_o = col_q;

endmodule

FILE: design/bbe_avg.sv
// Rounded mean of the in-frame window pixels: adds the three column sums, then
// divides by the neighbour count through a reciprocal multiply. Depends on bbe_pkg.
module bbe_avg import bbe_pkg::*; (
  input  logic      clk_i,
  input  logic      ld_i,
  input  col_sum_t  sum_l_i,
  input  col_sum_t  sum_m_i,
  input  col_sum_t  sum_r_i,
  input  win_mask_t mask_i,
  output rgb_t      avg_o
);

  localparam int unsigned PROD_W = NUM_W + REC_W;

  logic [1:0]       rows_n;
  logic [1:0]       cols_n;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num_r_q;
  logic [NUM_W-1:0] num_g_q;
  logic [NUM_W-1:0] num_b_q;
  logic [REC_W-1:0] rec_q;

  // 2*sum + n, so that the floor of num / 2n rounds half up
  function automatic logic [NUM_W-1:0] numer(input logic [COL_SUM_W-1:0] a,
                                             input logic [COL_SUM_W-1:0] b,
                                             input logic [COL_SUM_W-1:0] c,
                                             input logic [CNT_W-1:0] n);
    logic [WIN_SUM_W-1:0] s;
    s = WIN_SUM_W'(a) + WIN_SUM_W'(b) + WIN_SUM_W'(c);
    return {s, 1'b0} + NUM_W'(n);
  endfunction

  function automatic logic [CH_W-1:0] scale(input logic [NUM_W-1:0] x,
                                            input logic [REC_W-1:0] m);
    logic [PROD_W-1:0] p;
    p = PROD_W'(x) * PROD_W'(m);
    return p[REC_SHIFT +: CH_W];
  endfunction

  assign rows_n = 2'd1 + 2'(mask_i.top) + 2'(mask_i.bot);
  assign cols_n = 2'd1 + 2'(mask_i.left) + 2'(mask_i.right);
  assign cnt    = CNT_W'(rows_n) * CNT_W'(cols_n);

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      num_r_q <= numer(sum_l_i.red, sum_m_i.red, sum_r_i.red, cnt);
      num_g_q <= numer(sum_l_i.green, sum_m_i.green, sum_r_i.green, cnt);
      num_b_q <= numer(sum_l_i.blue, sum_m_i.blue, sum_r_i.blue, cnt);
      rec_q   <= recip(cnt);
    end
  end

  assign avg_o.red   = scale(num_r_q, rec_q);
  assign avg_o.green = scale(num_g_q, rec_q);
  assign avg_o.blue  = scale(num_b_q, rec_q);

endmodule

FILE: design/box_blur_3x3_edge_aware.sv
// Top level of the 3x3 edge-aware box blur: frame counters, control sequencer,
// line stores, a chain of three window cells, the averaging unit and the output register.
// Depends on bbe_pkg, bbe_line_store, bbe_cell and bbe_avg.
//
//   channel  | dir | handshake                  | payload
//   s_axis   | in  | tvalid / tready            | tdata: red, green, blue; tuser: func
//   m_axis   | out | tvalid / tready            | tdata: red, green, blue; tlast: frame_last
//   apb      | in  | psel, penable, pwrite      | paddr, pwdata, prdata (0: width, 4: height)
//
// An item that yields a pixel passes accept, window shift, sum, divide and load; an
// item that only advances the window passes accept and shift, an ignored item accept
// alone. The first drain of a one-row frame adds a line-store read and a second window
// shift. Outputs lag the input by one row plus one pixel. Reset clears counters and
// control; stored pixels read before being written are masked off. A new item is taken
// while a finished pixel waits on m_axis.
module box_blur_3x3_edge_aware import bbe_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,  // [7:0] red_in, [15:8] green_in, [23:16] blue_in
  input  logic              s_axis_tuser,  // [0] func
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,  // [7:0] red_out, [15:8] green_out, [23:16] blue_out
  output logic              m_axis_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW    = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned MX1   = (CW > RW) ? CW : RW;
  localparam int unsigned CMP_W = ((MX1 > DIM_W) ? MX1 : DIM_W) + 1;

  localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);
  localparam logic [CMP_W-1:0] MAX_H_C = CMP_W'(MAX_HEIGHT);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SHIFT = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_OUT   = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;

  logic [DIM_W-1:0] cfg_w_q;
  logic [DIM_W-1:0] cfg_h_q;
  logic [2:0]       state_q;
  logic [CW-1:0]    in_col_q;
  logic [RW-1:0]    in_row_q;
  logic [CW-1:0]    out_col_q;
  logic [RW-1:0]    out_row_q;
  logic [CW-1:0]    in_col_d;
  logic [RW-1:0]    in_row_d;
  logic [CW-1:0]    out_col_d;
  logic [RW-1:0]    out_row_d;
  logic             wr_q;
  logic             emit_q;
  logic             extra_q;
  logic             last_q;
  win_mask_t        mask_q;
  rgb_t             pix_q;
  logic             m_valid_q;
  rgb_t             m_data_q;
  logic             m_last_q;

  logic [CMP_W-1:0] w_eff;
  logic [CMP_W-1:0] h_eff;
  logic [CMP_W-1:0] in_col_x;
  logic [CMP_W-1:0] in_row_x;
  logic [CMP_W-1:0] out_col_x;
  logic [CMP_W-1:0] out_row_x;
  logic             cfg_wr;
  logic             s_acc;
  logic             is_pix;
  logic             complete;
  logic             past_first;
  logic             act;
  logic             emit;
  logic             extra;
  logic             out_free;
  logic             load_out;
  win_mask_t        mask_d;

  rgb_t             rd_upper;
  rgb_t             rd_lower;
  column_t          new_col;
  column_t          win_col [3];
  cell_mask_t       cmask   [3];
  col_sum_t         csum    [3];
  rgb_t             avg;
  logic             shift;

  // Clamp the frame size registers into the supported range
  always_comb begin
    if (cfg_w_q == '0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(cfg_w_q) > MAX_W_C) begin
      w_eff = MAX_W_C;
    end else begin
      w_eff = CMP_W'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      h_eff = CMP_W'(1);
    end else if (CMP_W'(cfg_h_q) > MAX_H_C) begin
      h_eff = MAX_H_C;
    end else begin
      h_eff = CMP_W'(cfg_h_q);
    end
  end

  assign in_col_x  = CMP_W'(in_col_q);
  assign in_row_x  = CMP_W'(in_row_q);
  assign out_col_x = CMP_W'(out_col_q);
  assign out_row_x = CMP_W'(out_row_q);

  assign cfg_wr        = psel & penable & pwrite;
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == REG_FRAME_HEIGHT) ? APB_DW'(cfg_h_q) : APB_DW'(cfg_w_q);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;

  // Decide at acceptance what the item does
  assign is_pix     = (s_axis_tuser == FUNC_PIXEL);
  assign complete   = (in_row_x >= h_eff);
  assign past_first = (in_row_x >= CMP_W'(2)) || ((in_row_x == CMP_W'(1)) && (in_col_q != '0));
  assign act        = is_pix ? !complete : complete;
  assign emit       = is_pix ? (!complete && past_first) : complete;
  // A one-row frame has produced no output before draining: the window runs one behind
  assign extra      = !is_pix && complete && (h_eff == CMP_W'(1))
                      && (out_row_q == '0) && (out_col_q == '0);

  assign mask_d.top   = (out_row_q != '0);
  assign mask_d.bot   = (out_row_x + CMP_W'(1)) < h_eff;
  assign mask_d.left  = (out_col_q != '0);
  assign mask_d.right = (out_col_x + CMP_W'(1)) < w_eff;

  // Raster position advance
  always_comb begin
    if ((in_col_x + CMP_W'(1)) == w_eff) begin
      in_col_d = '0;
      in_row_d = in_row_q + RW'(1);
    end else begin
      in_col_d = in_col_q + CW'(1);
      in_row_d = in_row_q;
    end
    if ((out_col_x + CMP_W'(1)) == w_eff) begin
      out_col_d = '0;
      out_row_d = out_row_q + RW'(1);
    end else begin
      out_col_d = out_col_q + CW'(1);
      out_row_d = out_row_q;
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;
  assign load_out = (state_q == ST_OUT) && out_free;
  assign shift    = (state_q == ST_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q   <= RST_FRAME_WIDTH;
      cfg_h_q   <= RST_FRAME_HEIGHT;
      state_q   <= ST_IDLE;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      wr_q      <= 1'b0;
      emit_q    <= 1'b0;
      extra_q   <= 1'b0;
      last_q    <= 1'b0;
      mask_q    <= '0;
      m_valid_q <= 1'b0;
      m_last_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            wr_q    <= is_pix;
            emit_q  <= emit;
            extra_q <= extra;
            last_q  <= (out_row_x + CMP_W'(1) == h_eff) && (out_col_x + CMP_W'(1) == w_eff);
            mask_q  <= mask_d;
            state_q <= act ? ST_SHIFT : ST_IDLE;
          end
        end
        ST_SHIFT: begin
          if (extra_q) begin
            in_col_q <= in_col_d;
            in_row_q <= in_row_d;
            extra_q  <= 1'b0;
            state_q  <= ST_READ;
          end else if (emit_q) begin
            if (last_q) begin
              // frame done: start over
              in_col_q  <= '0;
              in_row_q  <= '0;
              out_col_q <= '0;
              out_row_q <= '0;
            end else begin
              in_col_q  <= in_col_d;
              in_row_q  <= in_row_d;
              out_col_q <= out_col_d;
              out_row_q <= out_row_d;
            end
            state_q <= ST_SUM;
          end else begin
            in_col_q <= in_col_d;
            in_row_q <= in_row_d;
            state_q  <= ST_IDLE;
          end
        end
        ST_READ: begin
          state_q <= ST_SHIFT;
        end
        ST_SUM: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (load_out) begin
        m_valid_q <= 1'b1;
        m_last_q  <= last_q;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      // A register write restarts the frame
      if (cfg_wr) begin
        if (paddr[2] == REG_FRAME_HEIGHT) begin
          cfg_h_q <= pwdata[DIM_W-1:0];
        end else begin
          cfg_w_q <= pwdata[DIM_W-1:0];
        end
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      pix_q <= s_axis_tdata;
    end
    if (load_out) begin
      m_data_q <= avg;
    end
  end

  bbe_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_lines (
    .clk_i      (clk_i),
    .rd_en_i    (s_acc || (state_q == ST_READ)),
    .wr_en_i    (shift && wr_q),
    .addr_i     (in_col_q),
    .wr_upper_i (rd_lower),
    .wr_lower_i (pix_q),
    .rd_upper_o (rd_upper),
    .rd_lower_o (rd_lower)
  );

  assign new_col.top = rd_upper;
  assign new_col.mid = rd_lower;
  assign new_col.bot = pix_q;

  // Cell 0 is the right-hand (newest) column, cell 2 the left-hand one
  assign cmask[0] = '{col_en: mask_q.right, top_en: mask_q.top, bot_en: mask_q.bot};
  assign cmask[1] = '{col_en: 1'b1,         top_en: mask_q.top, bot_en: mask_q.bot};
  assign cmask[2] = '{col_en: mask_q.left,  top_en: mask_q.top, bot_en: mask_q.bot};

  for (genvar gi = 0; gi < 3; gi++) begin : g_cell
    if (gi == 0) begin : g_head
      bbe_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .col_i   (new_col),
        .mask_i  (cmask[gi]),
        .col_o   (win_col[gi]),
        .sum_o   (csum[gi])
      );
    end else begin : g_link
      bbe_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .col_i   (win_col[gi-1]),
        .mask_i  (cmask[gi]),
        .col_o   (win_col[gi]),
        .sum_o   (csum[gi])
      );
    end
  end

  bbe_avg u_avg (
    .clk_i   (clk_i),
    .ld_i    (state_q == ST_SUM),
    .sum_l_i (csum[2]),
    .sum_m_i (csum[1]),
    .sum_r_i (csum[0]),
    .mask_i  (mask_q),
    .avg_o   (avg)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

FILE: verif/testbench.sv
// Self-checking bench for box_blur_3x3_edge_aware: random bursts of pixel and drain items,
// an in-bench blur predictor and an output monitor with its own stall pattern.
// Depends on bbe_pkg and the RTL under design/.
`timescale 1ns / 1ps

module testbench;
  import bbe_pkg::*;

  localparam int unsigned HIST_DEPTH    = 2 * DEF_MAX_WIDTH + 3;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT   = 800000;
  localparam int unsigned RANDOM_ITEMS  = 750;
  localparam int unsigned MAX_REPORTS   = 60;

  // Checkerboard with a few odd values; exercises half-up rounding at every border class
  localparam logic [23:0] CHECKER [9] = '{
    24'hFFFFFF, 24'h000000, 24'hFFFFFF,
    24'h000000, 24'hFEFDFC, 24'h000000,
    24'hFFFFFF, 24'h000102, 24'h808080
  };

  typedef struct packed {
    logic func;
    rgb_t pix;
  } pix_item_t;

  typedef struct packed {
    rgb_t pix;
    logic last;
  } blur_px_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata  = '0;  // [7:0] red_in, [15:8] green_in, [23:16] blue_in
  logic              s_axis_tuser  = FUNC_PIXEL;  // [0] func
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;  // [7:0] red_out, [15:8] green_out, [23:16] blue_out
  logic              m_axis_tlast;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [APB_AW-1:0] paddr         = '0;
  logic [APB_DW-1:0] pwdata        = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Blur predictor state
  rgb_t             pix_hist [HIST_DEPTH];
  logic [DIM_W-1:0] width_reg  = RST_FRAME_WIDTH;
  logic [DIM_W-1:0] height_reg = RST_FRAME_HEIGHT;
  int unsigned      in_col     = 0;
  int unsigned      in_row     = 0;
  int unsigned      out_cnt    = 0;

  pix_item_t   feed_q [$];
  blur_px_t    blur_want [$];
  pix_item_t   cur_item;
  logic        next_valid;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  int unsigned err_cnt    = 0;
  int unsigned rand_items = 0;
  logic [31:0] cycle_cnt  = '0;

  box_blur_3x3_edge_aware uut (.*);

  always #5 clk_i = ~clk_i;

  function automatic int unsigned eff_size(input logic [DIM_W-1:0] v, input int unsigned lim);
    if (v == '0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  function automatic void blur_emit(input int unsigned w, input int unsigned h);
    int unsigned r, c, n, idx;
    int unsigned sum_r, sum_g, sum_b;
    int          rr, cc;
    blur_px_t    res;
    r = out_cnt / w;
    c = out_cnt % w;
    n = 0;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = int'(r) + dr;
        cc = int'(c) + dc;
        if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w)) begin
          idx = (rr * w + cc) % HIST_DEPTH;
          sum_r += pix_hist[idx].red;
          sum_g += pix_hist[idx].green;
          sum_b += pix_hist[idx].blue;
          n++;
        end
      end
    end
    res.pix.red   = 8'((2 * sum_r + n) / (2 * n));
    res.pix.green = 8'((2 * sum_g + n) / (2 * n));
    res.pix.blue  = 8'((2 * sum_b + n) / (2 * n));
    out_cnt++;
    res.last = (out_cnt >= w * h);
    if (res.last) begin
      in_col  = 0;
      in_row  = 0;
      out_cnt = 0;
    end
    blur_want.push_back(res);
  endfunction

  function automatic void blur_accept(input pix_item_t it);
    int unsigned w, h, n;
    logic        complete;
    w = eff_size(width_reg, DEF_MAX_WIDTH);
    h = eff_size(height_reg, DEF_MAX_HEIGHT);
    complete = (in_row >= h);
    if (it.func == FUNC_PIXEL) begin
      if (!complete) begin
        n = in_row * w + in_col;
        pix_hist[n % HIST_DEPTH] = it.pix;
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
        if (n >= w + 1 && out_cnt < w * h) blur_emit(w, h);
      end
    end else if (complete && out_cnt < w * h) begin
      blur_emit(w, h);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      if (err_cnt < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  function automatic rgb_t rand_pix();
    return rgb_t'(24'($urandom));
  endfunction

  function automatic void push_item(input logic func, input rgb_t pix);
    pix_item_t it;
    it.func = func;
    it.pix  = pix;
    feed_q.push_back(it);
  endfunction

  // Sender: bursts of items with random gaps, now and then a long unbroken run
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        blur_accept(cur_item);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (feed_q.size() != 0) begin
          cur_item = feed_q.pop_front();
          s_axis_tdata <= cur_item.pix;
          s_axis_tuser <= cur_item.func;
          next_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                     : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // Receiver: compare against the oldest prediction; stall mode rotates through four patterns
  always @(posedge clk_i) begin
    blur_px_t want;
    rgb_t     got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = rgb_t'(m_axis_tdata);
        if (blur_want.size() == 0) begin
          if (err_cnt < MAX_REPORTS)
            $display("%0t: unexpected pixel, expected none actual %h last %b",
                     $time, m_axis_tdata, m_axis_tlast);
          err_cnt++;
        end else begin
          want = blur_want.pop_front();
          check_field("red_out", want.pix.red, got.red);
          check_field("green_out", want.pix.green, got.green);
          check_field("blue_out", want.pix.blue, got.blue);
          check_field("frame_last", want.last, m_axis_tlast);
        end
      end
      case (cycle_cnt[8:7])
        2'd0:    m_axis_tready <= 1'b1;
        2'd1:    m_axis_tready <= cycle_cnt[0];
        2'd2:    m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d pixels outstanding", $time, blur_want.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic cfg_write(input logic idx, input logic [DIM_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
    in_col  = 0;
    in_row  = 0;
    out_cnt = 0;
  endtask

  // Hold until every item is taken and every pixel is out, then let the pipeline go quiet
  task automatic settle();
    while (feed_q.size() != 0 || s_axis_tvalid || blur_want.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One frame of w x h pixels and its flush; noise adds items the block must drop
  task automatic queue_frame(input int unsigned w, input int unsigned h, input bit noisy);
    int unsigned total, flush;
    total = w * h;
    flush = (total < w + 1) ? total : w + 1;
    for (int unsigned p = 0; p < total; p++) begin
      if (noisy && $urandom_range(0, 5) == 0) push_item(FUNC_DRAIN, rand_pix());
      push_item(FUNC_PIXEL, rand_pix());
      rand_items++;
    end
    if (noisy) repeat ($urandom_range(0, 2)) push_item(FUNC_PIXEL, rand_pix());
    repeat (flush) begin
      push_item(FUNC_DRAIN, rand_pix());
      rand_items++;
    end
    if (noisy && $urandom_range(0, 1) == 1) push_item(FUNC_DRAIN, rand_pix());
  endtask

  initial begin
    int unsigned w, h;
    pix_hist = '{default: '0};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset size is 640 x 480: a few pixels yield nothing and an early drain is dropped
    repeat (3) push_item(FUNC_PIXEL, rand_pix());
    push_item(FUNC_DRAIN, rand_pix());
    settle();

    // 3 x 3 frame: corners, edges and one interior pixel
    cfg_write(REG_FRAME_WIDTH, 11'd3);
    cfg_write(REG_FRAME_HEIGHT, 11'd3);
    foreach (CHECKER[i]) begin
      push_item(FUNC_PIXEL, rgb_t'(CHECKER[i]));
      if (i == 1) push_item(FUNC_DRAIN, rand_pix());
    end
    push_item(FUNC_PIXEL, rand_pix());
    repeat (5) push_item(FUNC_DRAIN, rand_pix());
    settle();

    // Zero sizes act as one pixel
    cfg_write(REG_FRAME_WIDTH, '0);
    cfg_write(REG_FRAME_HEIGHT, '0);
    repeat (2) begin
      push_item(FUNC_PIXEL, rand_pix());
      push_item(FUNC_DRAIN, rand_pix());
    end
    settle();

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
      h = $urandom_range(1, 5);
      cfg_write(REG_FRAME_WIDTH, DIM_W'(w));
      cfg_write(REG_FRAME_HEIGHT, DIM_W'(h));
      repeat ($urandom_range(1, 3)) queue_frame(w, h, $urandom_range(0, 3) == 0);
      // Leave a frame unfinished now and then; the next write restarts it
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, w * h)) begin
          push_item(FUNC_PIXEL, rand_pix());
          rand_items++;
        end
      end
      settle();
    end

    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/bbe_pkg.sv
design/bbe_line_store.sv
design/bbe_cell.sv
design/bbe_avg.sv
design/box_blur_3x3_edge_aware.sv
verif/testbench.sv
